>>> sv/pcg32_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pcg32 package
// shared types, constants and arithmetic helpers of the pcg32 generator
// ----------------------------------------------------------------------------
package pcg32_pkg;

  localparam logic [63:0] LcgMult = 64'd6364136223846793005;
  localparam logic [63:0] IncReset = 64'd1;
  localparam int unsigned QueueDepth = 2;

  typedef enum logic {
    CMD_SEED = 1'b0,
    CMD_DRAW = 1'b1
  } cmd_t;

  typedef struct packed {
    cmd_t        cmd;
    logic [63:0] inc;
    logic [63:0] base;
  } job_t;

  // low 64 bits of a * multiplier, as three 32 bit partial products
  function automatic logic [63:0] mul_lcg(input logic [63:0] a);
    logic [63:0] ll;
    logic [63:0] lh;
    logic [63:0] hl;
    logic [31:0] mid;
    ll = 64'(a[31:0]) * 64'(LcgMult[31:0]);
    lh = 64'(a[31:0]) * 64'(LcgMult[63:32]);
    hl = 64'(a[63:32]) * 64'(LcgMult[31:0]);
    mid = lh[31:0] + hl[31:0];
    return ll + {mid, 32'd0};
  endfunction

  // xsh-rr output permutation
  function automatic logic [31:0] permute(input logic [63:0] s);
    logic [63:0] x;
    logic [31:0] xs;
    logic [4:0]  rot;
    x = (s >> 18) ^ s;
    xs = x[58:27];
    rot = s[63:59];
    return (xs >> rot) | (xs << (5'(6'd32 - {1'b0, rot})));
  endfunction

  // float32 bits of sign * a / 2^scale, a nonzero and below 2^24
  function automatic logic [31:0] make_float(input logic neg, input logic [23:0] a,
                                             input logic [7:0] scale);
    logic [4:0]  p;
    logic [7:0]  ex;
    logic [23:0] sh;
    p = 5'd0;
    for (int i = 0; i < 24; i++) begin
      if (a[i]) begin
        p = 5'(i);
      end
    end
    ex = 8'd127 + {3'd0, p} - scale;
    sh = a << (5'd23 - p);
    return {neg, ex, sh[22:0]};
  endfunction

endpackage
`default_nettype wire

>>> sv/pcg_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pcg channels
// valid/ready channels for commands and random results
// ----------------------------------------------------------------------------
interface pcg_in_if;
  logic                 valid;
  logic                 ready;
  pcg32_pkg::cmd_t      cmd;
  logic [63:0]          seed_state;
  logic [62:0]          seed_sequence;
  modport source (output valid, cmd, seed_state, seed_sequence, input ready);
  modport sink (input valid, cmd, seed_state, seed_sequence, output ready);
endinterface

interface pcg_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] random_word;
  logic [31:0] unit_float_bits;
  logic [31:0] signed_float_bits;
  modport source (output valid, random_word, unit_float_bits, signed_float_bits,
                  input ready);
  modport sink (input valid, random_word, unit_float_bits, signed_float_bits,
                output ready);
endinterface
`default_nettype wire

>>> sv/pcg_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pcg front
// passes commands through and precomputes the seed increment and base
// ----------------------------------------------------------------------------
module pcg_front (
  pcg_in_if.sink          in_ch,
  output logic            push_valid,
  input  logic            push_ready,
  output pcg32_pkg::job_t push_job
);

  always_comb begin
    push_valid    = in_ch.valid;
    in_ch.ready   = push_ready;
    push_job.cmd  = in_ch.cmd;
    push_job.inc  = {in_ch.seed_sequence, 1'b1};
    push_job.base = {in_ch.seed_sequence, 1'b1} + in_ch.seed_state;
  end

endmodule
`default_nettype wire

>>> sv/pcg_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pcg queue
// short job queue between front and back
// ----------------------------------------------------------------------------
module pcg_queue #(
  parameter int unsigned Depth = pcg32_pkg::QueueDepth
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push_valid,
  output logic            push_ready,
  input  pcg32_pkg::job_t push_job,
  output logic            pop_valid,
  input  logic            pop_ready,
  output pcg32_pkg::job_t pop_job
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  pcg32_pkg::job_t mem_r [Depth];
  logic [PtrW-1:0] wr_r, wr_nxt, rd_r, rd_nxt;
  logic [CntW-1:0] cnt_r, cnt_nxt;
  logic            do_push, do_pop;

  always_comb begin
    push_ready = (cnt_r != CntW'(Depth));
    pop_valid  = (cnt_r != '0);
    pop_job    = mem_r[rd_r];
    do_push    = push_valid && push_ready;
    do_pop     = pop_valid && pop_ready;
    wr_nxt     = wr_r;
    rd_nxt     = rd_r;
    if (do_push) begin
      wr_nxt = (wr_r == PtrW'(Depth - 1)) ? '0 : wr_r + 1'b1;
    end
    if (do_pop) begin
      rd_nxt = (rd_r == PtrW'(Depth - 1)) ? '0 : rd_r + 1'b1;
    end
    cnt_nxt = cnt_r + CntW'(do_push) - CntW'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_r] <= push_job;
    end
  end

endmodule
`default_nettype wire

>>> sv/pcg_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pcg back
// lcg state engine, xsh-rr permutation and float conversion
// ----------------------------------------------------------------------------
module pcg_back (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            pop_valid,
  output logic            pop_ready,
  input  pcg32_pkg::job_t pop_job,
  pcg_out_if.source       out_ch
);

  logic [63:0] state_r, state_nxt, inc_r, inc_nxt;
  logic        ov_r, ov_nxt;
  logic [31:0] word_r, unit_r, sgn_r;
  logic [31:0] word, ubits, sbits;
  logic [23:0] m;
  logic        do_pop, is_draw;

  always_comb begin
    is_draw   = (pop_job.cmd == pcg32_pkg::CMD_DRAW);
    pop_ready = !is_draw || !ov_r || out_ch.ready;
    do_pop    = pop_valid && pop_ready;
    word      = pcg32_pkg::permute(state_r);
    m         = word[31:8];
    ubits     = 32'd0;
    sbits     = 32'd0;
    if (m != 24'd0) begin
      ubits = pcg32_pkg::make_float(1'b0, m, 8'd24);
    end
    if (m[23]) begin
      if (m[22:0] != 23'd0) begin
        sbits = pcg32_pkg::make_float(1'b0, {1'b0, m[22:0]}, 8'd23);
      end
    end else begin
      sbits = pcg32_pkg::make_float(1'b1, 24'h800000 - m, 8'd23);
    end
    state_nxt = state_r;
    inc_nxt   = inc_r;
    ov_nxt    = ov_r && !out_ch.ready;
    if (do_pop) begin
      if (is_draw) begin
        state_nxt = pcg32_pkg::mul_lcg(state_r) + inc_r;
        ov_nxt    = 1'b1;
      end else begin
        state_nxt = pcg32_pkg::mul_lcg(pop_job.base) + pop_job.inc;
        inc_nxt   = pop_job.inc;
      end
    end
    out_ch.valid             = ov_r;
    out_ch.random_word       = word_r;
    out_ch.unit_float_bits   = unit_r;
    out_ch.signed_float_bits = sgn_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= 64'd0;
      inc_r   <= pcg32_pkg::IncReset;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      inc_r   <= inc_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_pop && is_draw) begin
      word_r <= word;
      unit_r <= ubits;
      sgn_r  <= sbits;
    end
  end

endmodule
`default_nettype wire

>>> sv/pcg32_random_generator.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pcg32 random generator
// path: a draw command is written into the queue, then its result into the output register
// throughput: one command per cycle while the output channel does not stall a draw, set by the lcg multiply-add
// a seed command gives no result
// reset: state zero, increment one, queue and output register empty
// ----------------------------------------------------------------------------
module pcg32_random_generator #(
  parameter int unsigned QueueDepth = pcg32_pkg::QueueDepth
) (
  input  wire       clk,
  input  wire       rst_n,
  pcg_in_if.sink    in_ch,
  pcg_out_if.source out_ch
);

  logic            push_valid, push_ready, pop_valid, pop_ready;
  pcg32_pkg::job_t push_job, pop_job;

  pcg_front u_front (
    .in_ch      (in_ch),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_job   (push_job)
  );

  pcg_queue #(.Depth(QueueDepth)) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_job   (push_job),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_job    (pop_job)
  );

  pcg_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_job   (pop_job),
    .out_ch    (out_ch)
  );

endmodule
`default_nettype wire

>>> test/tb_pcg32_random_generator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcg32 random generator testbench
// drives seed and draw commands through the input channel with bursty timing,
// predicts each draw word and its two float patterns with an independent
// xsh-rr model, and checks every output transfer in order
// ----------------------------------------------------------------------------
module tb_pcg32_random_generator;

  typedef struct packed {
    pcg32_pkg::cmd_t cmd;
    logic [63:0]     seed_state;
    logic [62:0]     seed_sequence;
  } pcg_cmd_t;

  typedef struct packed {
    logic [31:0] word;
    logic [31:0] ufl;
    logic [31:0] sfl;
  } draw_res_t;

  logic clk;
  logic rst_n;

  pcg_in_if  in_ch ();
  pcg_out_if out_ch ();

  pcg32_random_generator uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  pcg_cmd_t  pending_cmds[$];
  draw_res_t expected_draws[$];
  logic [63:0] gen_state;
  logic [63:0] gen_inc;
  int unsigned fail_count;
  int unsigned draw_count;
  int unsigned seed_count;
  int unsigned cycle_count;
  int unsigned burst_left;
  int unsigned gap_left;
  int unsigned hold_left;
  bit          hold_done;

  localparam logic [63:0] Mult = 64'd6364136223846793005;
  localparam int unsigned CycleLimit = 200000;

  initial clk = 1'b0;
  always #10 clk = ~clk;

  function automatic logic [31:0] xsh_rr(input logic [63:0] s);
    logic [63:0] x;
    logic [31:0] xs;
    int          r;
    x = (s >> 18) ^ s;
    xs = x[58:27];
    r = int'(s[63:59]);
    return (r == 0) ? xs : ((xs >> r) | (xs << (32 - r)));
  endfunction

  function automatic logic [31:0] to_float(input logic neg, input logic [23:0] a,
                                           input int scale);
    int          p;
    logic [23:0] m;
    p = 0;
    for (int i = 23; i >= 0; i--) begin
      if (a[i] && p == 0) begin
        p = i;
        break;
      end
    end
    m = a << (23 - p);
    return {neg, 8'(127 + p - scale), m[22:0]};
  endfunction

  task automatic enqueue_cmd(input pcg_cmd_t c);
    pending_cmds = {pending_cmds, c};
  endtask

  task automatic predict_generator(input pcg_cmd_t c);
    logic [31:0] w;
    logic [23:0] m;
    draw_res_t   r;
    if (c.cmd == pcg32_pkg::CMD_SEED) begin
      gen_inc = {c.seed_sequence, 1'b1};
      gen_state = gen_inc;
      gen_state = gen_state + c.seed_state;
      gen_state = gen_state * Mult + gen_inc;
    end else begin
      w = xsh_rr(gen_state);
      gen_state = gen_state * Mult + gen_inc;
      m = w[31:8];
      r.word = w;
      r.ufl = (m == 0) ? 32'd0 : to_float(1'b0, m, 24);
      if (m[23]) begin
        r.sfl = (m == 24'h800000) ? 32'd0 : to_float(1'b0, m - 24'h800000, 23);
      end else begin
        r.sfl = to_float(1'b1, 24'h800000 - m, 23);
      end
      expected_draws = {expected_draws, r};
    end
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch %s: got %08h want %08h at %0t", what, got, want, $realtime);
    fail_count++;
  endtask

  function automatic pcg_cmd_t rand_cmd(input bit draw);
    pcg_cmd_t c;
    c.cmd = draw ? pcg32_pkg::CMD_DRAW : pcg32_pkg::CMD_SEED;
    c.seed_state = {$urandom, $urandom};
    c.seed_sequence = 63'({$urandom, $urandom});
    return c;
  endfunction

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      burst_left <= 0;
      gap_left <= 0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        predict_generator(pcg_cmd_t'({in_ch.cmd, in_ch.seed_state, in_ch.seed_sequence}));
        void'(pending_cmds.pop_front());
      end
      if ((in_ch.valid && !in_ch.ready)) begin
        // hold the offered item
      end else if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        in_ch.valid <= 1'b0;
      end else if (pending_cmds.size() > 0) begin
        pcg_cmd_t c;
        c = pending_cmds[0];
        in_ch.valid <= 1'b1;
        in_ch.cmd <= c.cmd;
        in_ch.seed_state <= c.seed_state;
        in_ch.seed_sequence <= c.seed_sequence;
        if (burst_left == 0) begin
          burst_left <= $urandom_range(1, 30);
          gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // monitor and receiver stall pattern
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      hold_left <= 0;
      hold_done <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_draws.size() == 0) begin
          report_mismatch("unexpected transfer", out_ch.random_word, 32'd0);
        end else begin
          draw_res_t e;
          e = expected_draws.pop_front();
          if (out_ch.random_word !== e.word)
            report_mismatch("random_word", out_ch.random_word, e.word);
          if (out_ch.unit_float_bits !== e.ufl)
            report_mismatch("unit_float_bits", out_ch.unit_float_bits, e.ufl);
          if (out_ch.signed_float_bits !== e.sfl)
            report_mismatch("signed_float_bits", out_ch.signed_float_bits, e.sfl);
          draw_count++;
        end
      end
      if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        out_ch.ready <= 1'b0;
      end else if (!hold_done && cycle_count > 300) begin
        hold_done <= 1'b1;
        hold_left <= 60;
        out_ch.ready <= 1'b0;
      end else if (cycle_count % 256 < 64) begin
        out_ch.ready <= 1'b1;
      end else begin
        out_ch.ready <= ($urandom_range(0, 3) != 0);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("pcg32_random_generator regression: fail");
      $finish;
    end
  end

  initial begin
    pcg_cmd_t c;
    in_ch.valid = 1'b0;
    in_ch.cmd = pcg32_pkg::CMD_DRAW;
    in_ch.seed_state = '0;
    in_ch.seed_sequence = '0;
    out_ch.ready = 1'b0;
    gen_state = 64'd0;
    gen_inc = 64'd1;
    fail_count = 0;
    draw_count = 0;
    seed_count = 0;
    cycle_count = 0;
    rst_n = 1'b0;
    // draws before any seed, with seed fields set to show they are ignored
    c = rand_cmd(1'b1);
    enqueue_cmd(c);
    c.seed_state = '1;
    c.seed_sequence = '1;
    enqueue_cmd(c);
    enqueue_cmd(rand_cmd(1'b1));
    // extremes of the seed fields
    c = '{pcg32_pkg::CMD_SEED, 64'd0, 63'd0};
    enqueue_cmd(c);
    repeat (3) enqueue_cmd(rand_cmd(1'b1));
    c = '{pcg32_pkg::CMD_SEED, '1, '1};
    enqueue_cmd(c);
    repeat (3) enqueue_cmd(rand_cmd(1'b1));
    c = '{pcg32_pkg::CMD_SEED, 64'h8000_0000_0000_0000, 63'h4000_0000_0000_0000};
    enqueue_cmd(c);
    enqueue_cmd(rand_cmd(1'b0));
    repeat (3) enqueue_cmd(rand_cmd(1'b1));
    // seeded streams with random content, draws dominating
    for (int i = 0; i < 700; i++) begin
      enqueue_cmd(rand_cmd($urandom_range(0, 9) != 0));
    end
    foreach (pending_cmds[i]) if (pending_cmds[i].cmd == pcg32_pkg::CMD_SEED) seed_count++;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    wait (pending_cmds.size() == 0);
    @(posedge clk);
    wait (expected_draws.size() == 0);
    repeat (10) @(posedge clk);
    $display("covered %0d seed commands and %0d checked draws", seed_count, draw_count);
    if (fail_count == 0) begin
      $display("pcg32_random_generator regression: pass");
    end else begin
      $display("pcg32_random_generator regression: fail");
    end
    $finish;
  end

endmodule
